// ===== hw/rtl/subgroup_mean_limit_monitor_unit_macros.svh =====
// Assertion macros shared by the subgroup mean limit monitor RTL.
// Each macro expects clk_i and rst_ni in the enclosing scope.
`ifndef SUBGROUP_MEAN_LIMIT_MONITOR_UNIT_MACROS_SVH
`define SUBGROUP_MEAN_LIMIT_MONITOR_UNIT_MACROS_SVH

// check a property on every clock edge out of reset
`define SMLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that a condition never holds out of reset
`define SMLM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/smlm_pkg.sv =====
// Package for the subgroup mean limit monitor: widths, types, codes.
// No dependencies.
`timescale 1ns / 1ps

package smlm_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int MAX_GROUP_SIZE = 255;
  localparam int CNT_W          = 8;
  localparam int NUM_W          = 16;
  localparam int SUM_W          = SAMPLE_BITS + CNT_W;
  localparam int STEP_W         = $clog2(SUM_W);
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROUP_SIZE    = 3'd0,
    CFG_LOWER_CONTROL = 3'd1,
    CFG_UPPER_CONTROL = 3'd2,
    CFG_LOWER_WARNING = 3'd3,
    CFG_UPPER_WARNING = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_FINISH
  } back_state_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
    logic [NUM_W-1:0]        number;
  } group_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] lower_control;
    logic signed [SAMPLE_BITS-1:0] upper_control;
    logic signed [SAMPLE_BITS-1:0] lower_warning;
    logic signed [SAMPLE_BITS-1:0] upper_warning;
  } limits_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hw/rtl/smlm_if.sv =====
// Valid/ready channel interfaces for sample words and result words.
// Depends on smlm_pkg.
`timescale 1ns / 1ps

interface smlm_sample_if;
  import smlm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_stream;
  modport source (output valid, output sample, output end_of_stream, input ready);
  modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface smlm_result_if;
  import smlm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [NUM_W-1:0]              group_number;
  logic [CNT_W-1:0]              group_count;
  logic signed [SAMPLE_BITS-1:0] group_mean;
  logic                          status;
  modport source (output valid, output group_number, output group_count,
                  output group_mean, output status, input ready);
  modport sink   (input valid, input group_number, input group_count,
                  input group_mean, input status, output ready);
endinterface

// ===== hw/rtl/smlm_front.sv =====
// Front end: takes sample words, accumulates subgroups, queues closed groups.
// Depends on smlm_pkg and smlm_sample_if.
`timescale 1ns / 1ps

module smlm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [smlm_pkg::CNT_W-1:0] group_size_i,
  input  smlm_pkg::queue_status_t    queue_status_i,
  smlm_sample_if.sink                in_if,
  output logic                       push_o,
  output smlm_pkg::group_t           push_data_o
);
  import smlm_pkg::*;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [NUM_W-1:0]        num_q, num_d;
  logic signed [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]        cnt_next;
  logic [CNT_W-1:0]        eff_size;
  logic                    accept;
  logic                    close;

  assign in_if.ready = !queue_status_i.full;
  assign accept      = in_if.valid && in_if.ready;
  assign eff_size    = (group_size_i == '0) ? CNT_W'(1) : group_size_i;
  assign sum_next    = sum_q + SUM_W'(in_if.sample);
  assign cnt_next    = cnt_q + CNT_W'(1);
  assign close       = (cnt_next >= eff_size) || in_if.end_of_stream;

  assign push_o             = accept && close;
  assign push_data_o.sum    = sum_next;
  assign push_data_o.count  = cnt_next;
  assign push_data_o.number = num_q;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    num_d = num_q;
    if (accept) begin
      if (close) begin
        sum_d = '0;
        cnt_d = '0;
        num_d = (num_q == {NUM_W{1'b1}}) ? NUM_W'(1) : num_q + NUM_W'(1);
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      num_q <= NUM_W'(1);
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      num_q <= num_d;
    end
  end

endmodule

// ===== hw/rtl/smlm_queue.sv =====
// Two-entry queue of closed subgroups between front and back end.
// Depends on smlm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "subgroup_mean_limit_monitor_unit_macros.svh"

module smlm_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  smlm_pkg::group_t        push_data_i,
  input  logic                    pop_i,
  output smlm_pkg::group_t        pop_data_o,
  output smlm_pkg::queue_status_t status_o
);
  import smlm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  group_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   fill_q, fill_d;

  assign status_o.full  = (fill_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign status_o.empty = (fill_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + (PTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  `SMLM_NEVER(a_no_overflow, push_i && status_o.full && !pop_i, "queue overflow")
  `SMLM_NEVER(a_no_underflow, pop_i && status_o.empty, "queue underflow")
  `SMLM_ASSERT(a_fill_bound, fill_q <= (PTR_W+1)'(QUEUE_DEPTH), "queue fill out of range")

endmodule

// ===== hw/rtl/smlm_back.sv =====
// Back end: divides each queued subgroup sum by its count, checks limits,
// holds the result word. Depends on smlm_pkg, smlm_result_if and the macros.
`timescale 1ns / 1ps
`include "subgroup_mean_limit_monitor_unit_macros.svh"

module smlm_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  smlm_pkg::limits_t       limits_i,
  input  smlm_pkg::queue_status_t queue_status_i,
  input  smlm_pkg::group_t        grp_i,
  output logic                    pop_o,
  smlm_result_if.source           out_if
);
  import smlm_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  back_state_e             state_q, state_d;
  logic [SUM_W-1:0]        quo_q, quo_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [NUM_W-1:0]        num_q, num_d;
  logic                    neg_q, neg_d;
  logic [STEP_W-1:0]       step_q, step_d;

  logic                          out_valid_q, out_valid_d;
  logic [NUM_W-1:0]              out_num_q, out_num_d;
  logic [CNT_W-1:0]              out_cnt_q, out_cnt_d;
  logic signed [SAMPLE_BITS-1:0] out_mean_q, out_mean_d;
  logic                          out_status_q, out_status_d;

  logic [CNT_W:0]                rem_shift;
  logic [CNT_W:0]                rem_sub;
  logic                          rem_ge;
  logic [SUM_W-1:0]              sum_mag;
  logic [SAMPLE_BITS-1:0]        mean_mag;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic                          out_warn;
  logic                          out_ctrl;
  logic                          slot_free;

  assign rem_shift = {rem_q, quo_q[SUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, cnt_q};
  assign rem_ge    = (rem_shift >= {1'b0, cnt_q});
  assign sum_mag   = grp_i.sum[SUM_W-1] ? SUM_W'(-grp_i.sum) : SUM_W'(grp_i.sum);
  assign mean_mag  = quo_q[SAMPLE_BITS-1:0];
  assign mean      = neg_q ? $signed(-mean_mag) : $signed(mean_mag);
  assign out_warn  = (mean < limits_i.lower_warning) || (mean > limits_i.upper_warning);
  assign out_ctrl  = (mean < limits_i.lower_control) || (mean > limits_i.upper_control);
  assign slot_free = !out_valid_q || out_if.ready;

  always_comb begin
    state_d      = state_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    num_d        = num_q;
    neg_d        = neg_q;
    step_d       = step_q;
    pop_o        = 1'b0;
    out_valid_d  = out_valid_q && !out_if.ready;
    out_num_d    = out_num_q;
    out_cnt_d    = out_cnt_q;
    out_mean_d   = out_mean_q;
    out_status_d = out_status_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!queue_status_i.empty) begin
          pop_o   = 1'b1;
          quo_d   = sum_mag;
          rem_d   = '0;
          cnt_d   = grp_i.count;
          num_d   = grp_i.number;
          neg_d   = grp_i.sum[SUM_W-1];
          step_d  = '0;
          state_d = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        quo_d  = {quo_q[SUM_W-2:0], rem_ge};
        rem_d  = rem_ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) begin
          state_d = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (!out_warn) begin
          state_d = BK_IDLE;
        end else if (slot_free) begin
          out_valid_d  = 1'b1;
          out_num_d    = num_q;
          out_cnt_d    = cnt_q;
          out_mean_d   = mean;
          out_status_d = out_ctrl;
          state_d      = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    cnt_q        <= cnt_d;
    num_q        <= num_d;
    neg_q        <= neg_d;
    out_num_q    <= out_num_d;
    out_cnt_q    <= out_cnt_d;
    out_mean_q   <= out_mean_d;
    out_status_q <= out_status_d;
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.group_number = out_num_q;
  assign out_if.group_count  = out_cnt_q;
  assign out_if.group_mean   = out_mean_q;
  assign out_if.status       = out_status_q;

  `SMLM_ASSERT(a_pop_in_idle, pop_o |-> state_q == BK_IDLE, "pop outside idle")
  `SMLM_ASSERT(a_count_nonzero, pop_o |-> grp_i.count != '0, "zero subgroup count")
  `SMLM_ASSERT(a_rem_bound, state_q == BK_DIVIDE |-> rem_q < cnt_q, "remainder not below divisor")

endmodule

// ===== hw/rtl/subgroup_mean_limit_monitor_unit.sv =====
// Subgroup mean limit monitor, top level: configuration registers and
// front end, queue and divider back end. Depends on smlm_pkg, smlm_if, smlm_front, smlm_queue, smlm_back.
`timescale 1ns / 1ps

// Samples are taken one word per cycle while the queue is not full and
// summed into subgroups of group_size words (zero acts as one);
// end_of_stream closes a short subgroup. A closed subgroup goes into a
// two-entry queue; the back end pulls one at a time and works through it
// in order: load, a 24-step restoring divide of the sum magnitude by the
// count, limit check. A word is emitted only when the mean is outside the
// warning band, and then waits in an output register; the limit check
// holds until that register is free. Input stalls only while the queue is
// full, which happens when subgroups close faster than the back end ends them.
module subgroup_mean_limit_monitor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [smlm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [smlm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  smlm_sample_if.sink                     in_if,
  smlm_result_if.source                   out_if
);
  import smlm_pkg::*;

  logic [CNT_W-1:0] group_size_q;
  limits_t          limits_q;
  queue_status_t    queue_status;
  logic             push;
  group_t           push_data;
  logic             pop;
  group_t           pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q           <= CNT_W'(5);
      limits_q.lower_control <= SAMPLE_BITS'(-32768);
      limits_q.upper_control <= SAMPLE_BITS'(32767);
      limits_q.lower_warning <= SAMPLE_BITS'(-32768);
      limits_q.upper_warning <= SAMPLE_BITS'(32767);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GROUP_SIZE:    group_size_q           <= cfg_data_i[CNT_W-1:0];
        CFG_LOWER_CONTROL: limits_q.lower_control <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_UPPER_CONTROL: limits_q.upper_control <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_LOWER_WARNING: limits_q.lower_warning <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_UPPER_WARNING: limits_q.upper_warning <= cfg_data_i[SAMPLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  smlm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .group_size_i   (group_size_q),
    .queue_status_i (queue_status),
    .in_if          (in_if),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  smlm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (queue_status)
  );

  smlm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .limits_i       (limits_q),
    .queue_status_i (queue_status),
    .grp_i          (pop_data),
    .pop_o          (pop),
    .out_if         (out_if)
  );

endmodule

// ===== bench/smlm_chart_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the subgroup mean limit monitor: follows register writes, works out
// the flagged subgroups from accepted sample words and compares each result word.
// Depends on smlm_pkg and the channel interfaces in smlm_if.

module smlm_chart_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [smlm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [smlm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  smlm_sample_if                          sample_ch,
  smlm_result_if                          result_ch,
  output int                              mismatches_o,
  output int                              outstanding_o,
  output int                              compared_o
);
  import smlm_pkg::*;

  typedef struct {
    logic [NUM_W-1:0]              number;
    logic [CNT_W-1:0]              count;
    logic signed [SAMPLE_BITS-1:0] mean;
    logic                          beyond_control;
  } excursion_t;

  excursion_t       flagged_groups[$];
  logic [CNT_W-1:0] size_setting = CNT_W'(5);
  int               low_ctl = -32768;
  int               high_ctl = 32767;
  int               low_warn = -32768;
  int               high_warn = 32767;
  int               sum_so_far = 0;
  int               fill = 0;
  logic [NUM_W-1:0] group_no = NUM_W'(1);
  int               mismatches = 0;
  int               compared = 0;
  int               awaiting = 0;

  assign mismatches_o  = mismatches;
  assign outstanding_o = awaiting;
  assign compared_o    = compared;

  task automatic note_mismatch(input string what, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    if (mismatches < 20) begin
      $display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] value,
                               input logic closes);
    int         span;
    int         mean_v;
    excursion_t point;
    span = (size_setting == '0) ? 1 : int'(size_setting);
    if (span > MAX_GROUP_SIZE) begin
      span = MAX_GROUP_SIZE;
    end
    sum_so_far += int'(value);
    fill++;
    if (fill >= span || closes) begin
      mean_v = sum_so_far / fill;
      if (mean_v < low_warn || mean_v > high_warn) begin
        point.number         = group_no;
        point.count          = CNT_W'(fill);
        point.mean           = SAMPLE_BITS'(mean_v);
        point.beyond_control = (mean_v < low_ctl || mean_v > high_ctl);
        flagged_groups.push_back(point);
      end
      sum_so_far = 0;
      fill       = 0;
      group_no   = (group_no == '1) ? NUM_W'(1) : group_no + NUM_W'(1);
    end
  endtask

  task automatic check_result_word();
    excursion_t want;
    if (flagged_groups.size() == 0) begin
      note_mismatch("result word with no subgroup awaited, group_number",
                    32'(result_ch.group_number), 0);
    end else begin
      want = flagged_groups.pop_front();
      compared++;
      if (result_ch.group_number !== want.number) begin
        note_mismatch("group_number", 32'(result_ch.group_number), 32'(want.number));
      end
      if (result_ch.group_count !== want.count) begin
        note_mismatch("group_count", 32'(result_ch.group_count), 32'(want.count));
      end
      if (result_ch.group_mean !== want.mean) begin
        note_mismatch("group_mean", 32'(result_ch.group_mean), 32'(want.mean));
      end
      if (result_ch.status !== want.beyond_control) begin
        note_mismatch("status", 32'(result_ch.status), 32'(want.beyond_control));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_setting = CNT_W'(5);
      low_ctl      = -32768;
      high_ctl     = 32767;
      low_warn     = -32768;
      high_warn    = 32767;
      sum_so_far   = 0;
      fill         = 0;
      group_no     = NUM_W'(1);
      flagged_groups.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_GROUP_SIZE:    size_setting = cfg_data_i[CNT_W-1:0];
          CFG_LOWER_CONTROL: low_ctl = int'($signed(cfg_data_i));
          CFG_UPPER_CONTROL: high_ctl = int'($signed(cfg_data_i));
          CFG_LOWER_WARNING: low_warn = int'($signed(cfg_data_i));
          CFG_UPPER_WARNING: high_warn = int'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        absorb_sample(sample_ch.sample, sample_ch.end_of_stream);
      end
      if (result_ch.valid && result_ch.ready) begin
        check_result_word();
      end
    end
    awaiting = flagged_groups.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Top of the subgroup mean limit monitor bench: clock, reset, register writes and
// sample stimulus with random idling; smlm_chart_checker does the comparing.
// Depends on smlm_pkg, smlm_if, the monitor RTL and smlm_chart_checker.

module testbench;
  import smlm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int BACKLOG_HOLD   = 400;
  localparam int TARGET_WORDS   = 1450;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_e              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  steady = 1'b0;
  logic                  hold_request = 1'b0;
  int                    words_sent = 0;
  int                    settings_used = 0;
  int                    quiet_cycles = 0;
  int                    mismatches;
  int                    outstanding;
  int                    compared;

  smlm_sample_if sample_ch ();
  smlm_result_if result_ch ();

  subgroup_mean_limit_monitor_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_if       (sample_ch),
    .out_if      (result_ch)
  );

  smlm_chart_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .sample_ch     (sample_ch),
    .result_ch     (result_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .compared_o    (compared)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // hold off for a long stretch on request, so that the block backs up
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (BACKLOG_HOLD) @(posedge clk);
      end else begin
        result_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] clip16(input int v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic closes);
    while (!steady && $urandom_range(0, 99) < 33) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.sample        <= value;
    sample_ch.end_of_stream <= closes;
    do @(posedge clk); while (!sample_ch.ready);
    words_sent++;
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_chart(input int size, input int lc, input int uc,
                               input int lw, input int uw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GROUP_SIZE;
    cfg_data  <= CFG_DATA_W'(size);
    @(posedge clk);
    cfg_index <= CFG_LOWER_CONTROL;
    cfg_data  <= CFG_DATA_W'(lc);
    @(posedge clk);
    cfg_index <= CFG_UPPER_CONTROL;
    cfg_data  <= CFG_DATA_W'(uc);
    @(posedge clk);
    cfg_index <= CFG_LOWER_WARNING;
    cfg_data  <= CFG_DATA_W'(lw);
    @(posedge clk);
    cfg_index <= CFG_UPPER_WARNING;
    cfg_data  <= CFG_DATA_W'(uw);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random_phase(input int phase_no);
    int                            size;
    int                            span;
    int                            center;
    int                            spread;
    int                            w_band;
    int                            c_band;
    int                            words;
    int                            lc;
    int                            uc;
    int                            lw;
    int                            uw;
    int                            swap;
    logic signed [SAMPLE_BITS-1:0] value;
    case ($urandom_range(0, 9))
      0: size = 1;
      1: size = 0;
      2, 3, 4: size = $urandom_range(2, 8);
      5, 6, 7: size = $urandom_range(9, 40);
      8: size = $urandom_range(41, 120);
      default: size = $urandom_range(121, 255);
    endcase
    span  = (size == 0) ? 1 : size;
    words = (span > 40) ? 2 * span + $urandom_range(0, 20) : $urandom_range(40, 100);
    if (phase_no == 3 && words < 200) begin
      words = 200;
    end
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = $urandom_range(1, 64);
      default: spread = $urandom_range(65, 6000);
    endcase
    center = (spread == 0) ? 0 : int'($urandom_range(0, 40000)) - 20000;
    w_band = $urandom_range(0, (spread == 0) ? 20000 : spread);
    c_band = w_band + $urandom_range(0, (spread == 0) ? 12000 : spread);
    lw = int'(clip16(center - w_band));
    uw = int'(clip16(center + w_band));
    lc = int'(clip16(center - c_band));
    uc = int'(clip16(center + c_band));
    case ($urandom_range(0, 7))
      0: begin
        swap = lw;
        lw   = uw;
        uw   = swap;
      end
      1: begin
        swap = lc;
        lc   = uc;
        uc   = swap;
      end
      2: begin
        lc = int'(clip16(int'($urandom_range(0, 65535)) - 32768));
        uc = int'(clip16(int'($urandom_range(0, 65535)) - 32768));
        lw = int'(clip16(int'($urandom_range(0, 65535)) - 32768));
        uw = int'(clip16(int'($urandom_range(0, 65535)) - 32768));
      end
      default: ;
    endcase
    settle();
    program_chart(size, lc, uc, lw, uw);
    steady = (phase_no == 3);
    repeat (words) begin
      if (spread == 0) begin
        value = SAMPLE_BITS'($urandom());
      end else begin
        value = clip16(center + int'($urandom_range(0, 2 * spread)) - spread);
      end
      offer_sample(value, $urandom_range(0, 24) == 0);
    end
    steady = 1'b0;
  endtask

  initial begin
    int phase_no;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_GROUP_SIZE;
    cfg_data                <= '0;
    sample_ch.valid         <= 1'b0;
    sample_ch.sample        <= '0;
    sample_ch.end_of_stream <= 1'b0;
    rst_n                   <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: groups of five, band covers everything, so no words
    repeat (5) offer_sample(16'sh7FFF, 1'b0);
    offer_sample(16'sh7FFF, 1'b0);
    offer_sample(16'sh7FFF, 1'b0);
    offer_sample(16'sh8000, 1'b0);

    // shrink the size under a part-filled subgroup; crossed warning limits flag all
    settle();
    program_chart(2, -256, 256, 32767, -32768);
    offer_sample(16'sd1, 1'b0);
    offer_sample(-16'sd3, 1'b0);
    offer_sample(16'sd0, 1'b0);
    offer_sample(16'h5555, 1'b1);
    offer_sample(16'hAAAA, 1'b1);

    // size zero acts as one; crossed control limits
    settle();
    program_chart(0, 300, -300, 32767, -32768);
    offer_sample(16'sd0, 1'b0);
    offer_sample(-16'sd1, 1'b0);
    offer_sample(16'sd300, 1'b1);
    offer_sample(16'sh8000, 1'b0);
    offer_sample(16'sh7FFF, 1'b0);

    // back up the block: hold the result side while words keep coming
    settle();
    program_chart(1, -16384, 16384, 32767, -32768);
    hold_request = 1'b1;
    repeat (40) offer_sample(SAMPLE_BITS'($urandom()), 1'($urandom_range(0, 1)));

    // a largest subgroup at the bottom of the sample range, then a short one at the top
    settle();
    program_chart(255, -32767, 32766, -32767, 32766);
    repeat (255) offer_sample(16'sh8000, 1'b0);
    repeat (59) offer_sample(16'sh7FFF, 1'b0);
    offer_sample(16'sh7FFF, 1'b1);

    phase_no = 0;
    while (words_sent < TARGET_WORDS) begin
      run_random_phase(phase_no);
      phase_no++;
    end

    sample_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d sample words under %0d register settings, group sizes 0 to 255.",
             words_sent, settings_used);
    $display("Compared %0d flagged subgroup words; %0d mismatches.", compared, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/smlm_pkg.sv
hw/rtl/smlm_if.sv
hw/rtl/smlm_front.sv
hw/rtl/smlm_queue.sv
hw/rtl/smlm_back.sv
hw/rtl/subgroup_mean_limit_monitor_unit.sv
bench/smlm_chart_checker.sv
bench/testbench.sv
